// ----- rtl/core/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared sizes, codes and interface structs of the trie prefix counter.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Pool and alphabet sizing
    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 26;
    localparam int COUNT_BITS    = 24;

    // Fixed field widths of the item ports
    localparam int LETTER_W    = 5;
    localparam int OUT_COUNT_W = 24;

    // Letter modes as carried on i_mode
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Derived widths
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int ADDR_W      = $clog2(CHILD_DEPTH);
    localparam int ALU_W       = ((ADDR_W > COUNT_BITS) ? ADDR_W : COUNT_BITS) + 1;
    localparam int LETTER_CMP_W =
        (LETTER_W > $clog2(ALPHABET_SIZE + 1)) ? LETTER_W : $clog2(ALPHABET_SIZE + 1);
    localparam int CNT_EXT_W   = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_CHILD,
        ST_COUNT,
        ST_FINISH,
        ST_RESULT
    } t_state;

    // Shared unit operations
    typedef enum logic {
        ALU_SLOT,
        ALU_INC
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [ALU_W-1:0]  a;
        logic [ALU_W-1:0]  b;
        logic [ALU_W-1:0]  lim;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]  y;
        logic              over;
    } t_alu_rsp;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [NODE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_child_req;

    typedef struct packed {
        logic                  we;
        logic [NODE_W-1:0]     waddr;
        logic [COUNT_BITS-1:0] wdata;
        logic                  re;
        logic [NODE_W-1:0]     raddr;
    } t_count_req;

endpackage

// ----- rtl/core/tpc_ram.sv -----
// ----------------------------------------------------------------------------
// tpc_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpc_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/tpc_alu.sv -----
// ----------------------------------------------------------------------------
// tpc_alu
// Shared arithmetic unit: slot address (node * alphabet + letter) or
// increment, with a compare of the result against a limit.
// ----------------------------------------------------------------------------
module tpc_alu (
    input  tpc_pkg::t_alu_req i_req,
    output tpc_pkg::t_alu_rsp o_rsp
);

    logic [tpc_pkg::ALU_W-1:0] w_y;

    // Select the operation
    always_comb begin
        unique case (i_req.op)
            tpc_pkg::ALU_SLOT: begin
                w_y = i_req.a * tpc_pkg::ALU_W'(tpc_pkg::ALPHABET_SIZE) + i_req.b;
            end
            tpc_pkg::ALU_INC: begin
                w_y = i_req.a + tpc_pkg::ALU_W'(1);
            end
            default: begin
                w_y = '0;
            end
        endcase
    end

    // Flag a result beyond the limit
    assign o_rsp.y    = w_y;
    assign o_rsp.over = (w_y > i_req.lim);

endmodule

// ----- rtl/core/tpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpc_ctrl
// Sequencer of the trie walk: clears the child table after reset, then runs
// each letter through slot lookup, allocation and count update on the shared
// unit, and holds finished results in an output register.
// ----------------------------------------------------------------------------
module tpc_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [tpc_pkg::LETTER_W-1:0]      i_letter,
    input  logic                              i_word_end,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tpc_pkg::OUT_COUNT_W-1:0]   o_prefix_count,
    output logic                              o_pool_full,
    output tpc_pkg::t_alu_req                 o_alu_req,
    input  tpc_pkg::t_alu_rsp                 i_alu_rsp,
    output tpc_pkg::t_child_req               o_child_req,
    input  logic [tpc_pkg::NODE_W-1:0]        i_child_rdata,
    output tpc_pkg::t_count_req               o_count_req,
    input  logic [tpc_pkg::COUNT_BITS-1:0]    i_count_rdata
);

    tpc_pkg::t_state r_state, n_state;

    logic                             r_mode, n_mode;
    logic [tpc_pkg::LETTER_W-1:0]     r_letter, n_letter;
    logic                             r_word_end, n_word_end;
    logic [tpc_pkg::NODE_W-1:0]       r_cursor, n_cursor;
    logic [tpc_pkg::NODE_W-1:0]       r_free, n_free;
    logic                             r_missed, n_missed;
    logic                             r_overflowed, n_overflowed;
    logic [tpc_pkg::ADDR_W-1:0]       r_slot, n_slot;
    logic [tpc_pkg::ADDR_W-1:0]       r_clr, n_clr;
    logic                             r_out_valid, n_out_valid;
    logic [tpc_pkg::OUT_COUNT_W-1:0]  r_out_count, n_out_count;
    logic                             r_out_full, n_out_full;

    logic                             w_dead;
    logic                             w_letter_ok;
    logic [tpc_pkg::CNT_EXT_W-1:0]    w_cnt_ext;

    assign w_dead      = r_missed | r_overflowed;
    assign w_letter_ok = tpc_pkg::LETTER_CMP_W'(i_letter)
                         < tpc_pkg::LETTER_CMP_W'(tpc_pkg::ALPHABET_SIZE);
    assign w_cnt_ext   = tpc_pkg::CNT_EXT_W'(i_count_rdata);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tpc_pkg::ST_CLEAR;
            r_cursor     <= '0;
            r_free       <= '0;
            r_missed     <= 1'b0;
            r_overflowed <= 1'b0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_free       <= n_free;
            r_missed     <= n_missed;
            r_overflowed <= n_overflowed;
            r_clr        <= n_clr;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_letter    <= n_letter;
        r_word_end  <= n_word_end;
        r_slot      <= n_slot;
        r_out_count <= n_out_count;
        r_out_full  <= n_out_full;
    end

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_letter     = r_letter;
        n_word_end   = r_word_end;
        n_cursor     = r_cursor;
        n_free       = r_free;
        n_missed     = r_missed;
        n_overflowed = r_overflowed;
        n_slot       = r_slot;
        n_clr        = r_clr;
        n_out_valid  = r_out_valid & i_out_stall;
        n_out_count  = r_out_count;
        n_out_full   = r_out_full;

        o_alu_req.op  = tpc_pkg::ALU_INC;
        o_alu_req.a   = '0;
        o_alu_req.b   = '0;
        o_alu_req.lim = '0;

        o_child_req.we    = 1'b0;
        o_child_req.waddr = r_slot;
        o_child_req.wdata = '0;
        o_child_req.re    = 1'b0;
        o_child_req.raddr = '0;

        o_count_req.we    = 1'b0;
        o_count_req.waddr = r_cursor;
        o_count_req.wdata = '0;
        o_count_req.re    = 1'b0;
        o_count_req.raddr = r_cursor;

        unique case (r_state)
            tpc_pkg::ST_CLEAR: begin
                // Sweep the child table to "no child", one entry a cycle
                o_child_req.we    = 1'b1;
                o_child_req.waddr = r_clr;
                o_alu_req.a       = tpc_pkg::ALU_W'(r_clr);
                o_alu_req.lim     = tpc_pkg::ALU_W'(tpc_pkg::CHILD_DEPTH - 1);
                n_clr             = i_alu_rsp.y[tpc_pkg::ADDR_W-1:0];
                if (i_alu_rsp.over) begin
                    n_state = tpc_pkg::ST_IDLE;
                end
            end
            tpc_pkg::ST_IDLE: begin
                // Take the next item; a dead walk or a bad letter skips the lookup
                if (i_in_valid) begin
                    n_mode     = i_mode;
                    n_letter   = i_letter;
                    n_word_end = i_word_end;
                    if (w_dead) begin
                        n_state = tpc_pkg::ST_FINISH;
                    end else if (!w_letter_ok) begin
                        n_missed = 1'b1;
                        n_state  = tpc_pkg::ST_FINISH;
                    end else begin
                        n_state = tpc_pkg::ST_SLOT;
                    end
                end
            end
            tpc_pkg::ST_SLOT: begin
                // Form the slot address and read the child entry
                o_alu_req.op      = tpc_pkg::ALU_SLOT;
                o_alu_req.a       = tpc_pkg::ALU_W'(r_cursor);
                o_alu_req.b       = tpc_pkg::ALU_W'(r_letter);
                o_child_req.re    = 1'b1;
                o_child_req.raddr = i_alu_rsp.y[tpc_pkg::ADDR_W-1:0];
                n_slot            = i_alu_rsp.y[tpc_pkg::ADDR_W-1:0];
                n_state           = tpc_pkg::ST_CHILD;
            end
            tpc_pkg::ST_CHILD: begin
                if (i_child_rdata != '0) begin
                    // Follow an existing child; an insert reads its count
                    n_cursor = i_child_rdata;
                    if (r_mode == tpc_pkg::MODE_QUERY) begin
                        n_state = tpc_pkg::ST_FINISH;
                    end else begin
                        o_count_req.re    = 1'b1;
                        o_count_req.raddr = i_child_rdata;
                        n_state           = tpc_pkg::ST_COUNT;
                    end
                end else if (r_mode == tpc_pkg::MODE_QUERY) begin
                    // Query hits a missing child
                    n_missed = 1'b1;
                    n_state  = tpc_pkg::ST_FINISH;
                end else begin
                    // Allocate a new node unless the pool is used up
                    o_alu_req.a   = tpc_pkg::ALU_W'(r_free);
                    o_alu_req.lim = tpc_pkg::ALU_W'(tpc_pkg::NODE_COUNT - 1);
                    if (i_alu_rsp.over) begin
                        n_overflowed = 1'b1;
                    end else begin
                        n_free            = i_alu_rsp.y[tpc_pkg::NODE_W-1:0];
                        n_cursor          = i_alu_rsp.y[tpc_pkg::NODE_W-1:0];
                        o_child_req.we    = 1'b1;
                        o_child_req.wdata = i_alu_rsp.y[tpc_pkg::NODE_W-1:0];
                        o_count_req.we    = 1'b1;
                        o_count_req.waddr = i_alu_rsp.y[tpc_pkg::NODE_W-1:0];
                        o_count_req.wdata = tpc_pkg::COUNT_BITS'(1);
                    end
                    n_state = tpc_pkg::ST_FINISH;
                end
            end
            tpc_pkg::ST_COUNT: begin
                // Raise the count, saturating at the top
                o_alu_req.a   = tpc_pkg::ALU_W'(i_count_rdata);
                o_alu_req.lim = tpc_pkg::ALU_W'(tpc_pkg::COUNT_MAX);
                if (!i_alu_rsp.over) begin
                    o_count_req.we    = 1'b1;
                    o_count_req.wdata = i_alu_rsp.y[tpc_pkg::COUNT_BITS-1:0];
                end
                n_state = tpc_pkg::ST_FINISH;
            end
            tpc_pkg::ST_FINISH: begin
                // On the last letter fetch the count of the node reached
                if (!r_word_end) begin
                    n_state = tpc_pkg::ST_IDLE;
                end else begin
                    o_count_req.re = !w_dead;
                    n_state        = tpc_pkg::ST_RESULT;
                end
            end
            tpc_pkg::ST_RESULT: begin
                // Load the output register once it is free, then rewind
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = w_dead ? '0 : w_cnt_ext[tpc_pkg::OUT_COUNT_W-1:0];
                    n_out_full   = r_overflowed;
                    n_cursor     = '0;
                    n_missed     = 1'b0;
                    n_overflowed = 1'b0;
                    n_state      = tpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall     = (r_state != tpc_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_prefix_count = r_out_count;
    assign o_pool_full    = r_out_full;

endmodule

// ----- rtl/core/trie_prefix_counter_core.sv -----
// ----------------------------------------------------------------------------
// trie_prefix_counter_core
// Prefix-counting trie over a fixed node pool, fed one letter per item.
// ----------------------------------------------------------------------------
// Items: a letter is taken only when idle; an insert along an existing
//   child takes the longest path (slot address, child read, count update).
// Result: FINISH reads the final count and RESULT registers it, waiting out an output stall.
// Both the child table and the count store are single-read-port memories.
// Reset: after reset the child table is cleared, one entry a cycle, over
//   all NODE_COUNT * ALPHABET_SIZE entries; no item is taken meanwhile.
// ----------------------------------------------------------------------------
module trie_prefix_counter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_mode,
    input  logic [tpc_pkg::LETTER_W-1:0]     i_letter,
    input  logic                             i_word_end,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [tpc_pkg::OUT_COUNT_W-1:0]  o_prefix_count,
    output logic                             o_pool_full
);

    tpc_pkg::t_alu_req                  w_alu_req;
    tpc_pkg::t_alu_rsp                  w_alu_rsp;
    tpc_pkg::t_child_req                w_child_req;
    tpc_pkg::t_count_req                w_count_req;
    logic [tpc_pkg::NODE_W-1:0]         w_child_rdata;
    logic [tpc_pkg::COUNT_BITS-1:0]     w_count_rdata;

    // Sequencer
    tpc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_letter       (i_letter),
        .i_word_end     (i_word_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_prefix_count (o_prefix_count),
        .o_pool_full    (o_pool_full),
        .o_alu_req      (w_alu_req),
        .i_alu_rsp      (w_alu_rsp),
        .o_child_req    (w_child_req),
        .i_child_rdata  (w_child_rdata),
        .o_count_req    (w_count_req),
        .i_count_rdata  (w_count_rdata)
    );

    // Shared arithmetic unit
    tpc_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // Child table: one entry per node and letter
    tpc_ram #(
        .DEPTH (tpc_pkg::CHILD_DEPTH),
        .WIDTH (tpc_pkg::NODE_W)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (w_child_req.we),
        .i_waddr (w_child_req.waddr),
        .i_wdata (w_child_req.wdata),
        .i_re    (w_child_req.re),
        .i_raddr (w_child_req.raddr),
        .o_rdata (w_child_rdata)
    );

    // Prefix counts: one per node
    tpc_ram #(
        .DEPTH (tpc_pkg::NODE_COUNT),
        .WIDTH (tpc_pkg::COUNT_BITS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_count_req.we),
        .i_waddr (w_count_req.waddr),
        .i_wdata (w_count_req.wdata),
        .i_re    (w_count_req.re),
        .i_raddr (w_count_req.raddr),
        .o_rdata (w_count_rdata)
    );

    // A word that ran out of pool reports no count
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pool_full |-> o_prefix_count == '0)
        else $error("pool_full result with nonzero count");

    // Child table is written only while the block is busy
    a_child_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_child_req.we |-> o_in_stall)
        else $error("child table written while idle");

    // A count write never stores zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count_req.we |-> w_count_req.wdata != '0)
        else $error("count written as zero");

    // Child table is never read and written in the same cycle
    a_child_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_child_req.we && w_child_req.re))
        else $error("child table read and write collide");

endmodule
